// ===== design/bqve_pkg.sv =====
package bqve_pkg;

  // Operation codes of the input beat.
  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MAX_QUADS  = 1'b0;
  localparam logic CFG_SLOT_LIMIT = 1'b1;

  // Width of the slot counter; a batch never binds more than 32 slots.
  localparam int NS_W = 6;

  // Result kinds.
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // Q30 constants of the sine and cosine polynomials.
  localparam logic signed [32:0] K_ONE     = 33'sd1073741824;
  localparam logic signed [32:0] K_HALF_PI = 33'sd1686629713;
  localparam logic signed [32:0] KS_9      = 33'sd2959;
  localparam logic signed [32:0] KS_7      = 33'sd213044;
  localparam logic signed [32:0] KS_5      = 33'sd8947849;
  localparam logic signed [32:0] KS_3      = 33'sd178956971;
  localparam logic signed [32:0] KC_10     = 33'sd296;
  localparam logic signed [32:0] KC_8      = 33'sd26631;
  localparam logic signed [32:0] KC_6      = 33'sd1491308;
  localparam logic signed [32:0] KC_4      = 33'sd44739243;
  localparam logic signed [32:0] KC_2      = 33'sd536870912;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic               mark;
    logic               draw;
    logic [15:0]        mark_quads;
    logic [NS_W-1:0]    mark_slots;
    logic [4:0]         slot;
    logic [15:0]        tiling;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0]        angle;
    logic [31:0]        color;
  } job_t;

endpackage

// ===== design/bqve_ram.sv =====
module bqve_ram #(
  parameter int Width = 32,
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bqve_front.sv =====
module bqve_front import bqve_pkg::*; #(
  parameter int TEX_SLOTS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] size_x_i,
  input  logic signed [31:0] size_y_i,
  input  logic [15:0]        angle_i,
  input  logic [31:0]        color_rgba_i,
  input  logic               textured_i,
  input  logic [31:0]        texture_handle_i,
  input  logic [15:0]        tiling_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               push_o,
  output job_t               job_o,
  input  logic               full_i
);

  localparam int AW = (TEX_SLOTS > 1) ? $clog2(TEX_SLOTS) : 1;
  localparam logic [NS_W-1:0] LIM_MAX = NS_W'((TEX_SLOTS < 32) ? TEX_SLOTS : 32);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RD   = 2'd1;
  localparam logic [1:0] F_CMP  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [15:0]     qc_q, qc_d;
  logic [NS_W-1:0] ns_q, ns_d;
  logic [NS_W-1:0] idx_q, idx_d;
  logic [31:0]     handle_q, handle_d;
  job_t            job_q, job_d;
  logic [15:0]     max_quads_q;
  logic [NS_W-1:0] slot_limit_q;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_rdata;

  logic [15:0]     mq_eff;
  logic [NS_W-1:0] lim;

  // Slot table: handle of each bound texture in the current batch.
  bqve_ram #(
    .Width(32),
    .Depth(TEX_SLOTS),
    .AddrW(AW)
  ) u_slot_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(handle_q),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Effective limits after clamping.
  always_comb begin
    mq_eff = (max_quads_q == 16'd0) ? 16'd1 : max_quads_q;
    if (slot_limit_q < NS_W'(2)) begin
      lim = NS_W'(2);
    end else if (slot_limit_q > LIM_MAX) begin
      lim = LIM_MAX;
    end else begin
      lim = slot_limit_q;
    end
  end

  // Classification, batch accounting and slot search.
  always_comb begin
    state_d   = state_q;
    qc_d      = qc_q;
    ns_d      = ns_q;
    idx_d     = idx_q;
    handle_d  = handle_q;
    job_d     = job_q;
    ram_we    = 1'b0;
    ram_waddr = ns_q[AW-1:0];
    push_o    = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_BEGIN: begin
              qc_d = 16'd0;
              ns_d = NS_W'(1);
            end
            OP_END: begin
              job_d            = '0;
              job_d.mark       = 1'b1;
              job_d.mark_quads = qc_q;
              job_d.mark_slots = ns_q;
              state_d          = F_PUSH;
            end
            OP_DRAW: begin
              job_d.mark       = 1'b0;
              job_d.draw       = 1'b1;
              job_d.mark_quads = qc_q;
              job_d.mark_slots = ns_q;
              job_d.slot       = 5'd0;
              job_d.tiling     = 16'd256;
              job_d.pos_x      = pos_x_i;
              job_d.pos_y      = pos_y_i;
              job_d.pos_z      = pos_z_i;
              job_d.size_x     = size_x_i;
              job_d.size_y     = size_y_i;
              job_d.angle      = angle_i;
              job_d.color      = color_rgba_i;
              handle_d         = texture_handle_i;
              idx_d            = NS_W'(1);
              // Quad limit reached: flush before this quad.
              if (qc_q >= mq_eff) begin
                job_d.mark = 1'b1;
                qc_d       = 16'd0;
                ns_d       = NS_W'(1);
              end
              if (textured_i) begin
                job_d.tiling = tiling_i;
                state_d      = F_RD;
              end else begin
                state_d = F_PUSH;
              end
            end
            default: ;
          endcase
        end
      end
      F_RD: begin
        if (idx_q >= ns_q) begin
          // Miss: bind the next slot, flushing first if the table is full.
          if (ns_q >= lim) begin
            job_d.mark       = 1'b1;
            job_d.mark_quads = qc_q;
            job_d.mark_slots = ns_q;
            qc_d             = 16'd0;
            ram_waddr        = AW'(1);
            job_d.slot       = 5'd1;
            ns_d             = NS_W'(2);
          end else begin
            job_d.slot = ns_q[4:0];
            ns_d       = ns_q + NS_W'(1);
          end
          ram_we  = 1'b1;
          state_d = F_PUSH;
        end else begin
          state_d = F_CMP;
        end
      end
      F_CMP: begin
        if (ram_rdata == handle_q) begin
          job_d.slot = idx_q[4:0];
          state_d    = F_PUSH;
        end else begin
          idx_d   = idx_q + NS_W'(1);
          state_d = F_RD;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          if (job_q.draw) begin
            qc_d = qc_q + 16'd1;
          end
          state_d = F_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      qc_q         <= 16'd0;
      ns_q         <= NS_W'(1);
      max_quads_q  <= 16'd10000;
      slot_limit_q <= NS_W'(32);
    end else begin
      state_q <= state_d;
      qc_q    <= qc_d;
      ns_q    <= ns_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MAX_QUADS:  max_quads_q  <= cfg_data_i;
          CFG_SLOT_LIMIT: slot_limit_q <= cfg_data_i[NS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    handle_q <= handle_d;
    job_q    <= job_d;
  end

  assign in_stall_o = (state_q != F_IDLE);
  assign job_o      = job_q;

  // The slot counter always points inside the usable table.
  a_ns_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ns_q != '0) && (ns_q <= LIM_MAX))
    else $error("slot counter out of range");

  // A compare always follows the read that fetched its data.
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_CMP) |-> ($past(state_q) == F_RD))
    else $error("slot compare without read");

endmodule

// ===== design/bqve_queue.sv =====
module bqve_queue import bqve_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t din_i,
  output logic full_o,
  input  logic pop_i,
  output job_t dout_o,
  output logic empty_o
);

  job_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  // Two-entry job queue between front and back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= din_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign dout_o  = ent_q[rp_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("job queue overflow or underflow");

endmodule

// ===== design/bqve_back.sv =====
module bqve_back import bqve_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  job_t               job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [31:0] vert_x_o,
  output logic signed [31:0] vert_y_o,
  output logic signed [31:0] vert_z_o,
  output logic [31:0]        vert_color_o,
  output logic               tex_u_o,
  output logic               tex_v_o,
  output logic [4:0]         slot_o,
  output logic [15:0]        vert_tiling_o,
  output logic [15:0]        batch_quads_o,
  output logic [NS_W-1:0]    slots_used_o,
  output logic               last_o
);

  localparam int          ANG_SH   = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
  localparam logic [15:0] ANG_MASK = 16'hFFFF << ANG_SH;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MARK = 2'd1;
  localparam logic [1:0] B_CALC = 2'd2;
  localparam logic [1:0] B_VERT = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic        phase_q, phase_d;
  logic [1:0]  corner_q, corner_d;
  job_t        job_q, job_d;

  logic signed [32:0] x_q, x_d, x2_q, x2_d, t_q, t_d, s_q, s_d;
  logic signed [32:0] sn_q, sn_d, cs_q, cs_d;
  logic signed [65:0] prod_q, prod_d;
  logic signed [65:0] p1_q, p1_d, p2_q, p2_d, p3_q, p3_d, p4_q, p4_d;

  logic [15:0]        ang_m;
  logic [2:0]         oct;
  logic [29:0]        r_red;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_rnd;
  logic signed [32:0] mq;
  logic signed [32:0] c_new;

  logic               out_load;
  logic               emit_mark, emit_vert;
  logic               cx_neg, cy_neg;
  logic signed [66:0] sum_x, sum_y;
  logic signed [35:0] rx, ry;
  logic signed [36:0] vx, vy;
  logic signed [31:0] vx_sat, vy_sat;

  // Angle reduced to one octant, as a Q29 fraction of the octant.
  always_comb begin
    ang_m = job_q.angle & ANG_MASK;
    oct   = ang_m[15:13];
    if (oct[0]) begin
      r_red = 30'h2000_0000 - {1'b0, ang_m[12:0], 16'h0000};
    end else begin
      r_red = {1'b0, ang_m[12:0], 16'h0000};
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (step_q)
      4'd0:    begin mul_a = 33'($signed({3'b000, r_red})); mul_b = K_HALF_PI; end
      4'd1:    begin mul_a = x_q;  mul_b = x_q;  end
      4'd2:    begin mul_a = x2_q; mul_b = KS_9; end
      4'd6:    begin mul_a = x_q;  mul_b = t_q;  end
      4'd7:    begin mul_a = x2_q; mul_b = KC_10; end
      4'd12:   begin mul_a = 33'(job_q.size_x); mul_b = cs_q; end
      4'd13:   begin mul_a = 33'(job_q.size_y); mul_b = sn_q; end
      4'd14:   begin mul_a = 33'(job_q.size_x); mul_b = sn_q; end
      4'd15:   begin mul_a = 33'(job_q.size_y); mul_b = cs_q; end
      default: begin mul_a = x2_q; mul_b = t_q;  end
    endcase
    prod_rnd = prod_q + 66'sd536870912;
    mq       = 33'(prod_rnd >>> 30);
    c_new    = K_ONE - mq;
  end

  // Rotated corner offset, rounded half up, translated and saturated.
  always_comb begin
    cx_neg = (corner_q == 2'd0) || (corner_q == 2'd3);
    cy_neg = !corner_q[1];
    sum_x  = (cx_neg ? -67'(p1_q) : 67'(p1_q)) - (cy_neg ? -67'(p2_q) : 67'(p2_q));
    sum_y  = (cx_neg ? -67'(p3_q) : 67'(p3_q)) + (cy_neg ? -67'(p4_q) : 67'(p4_q));
    rx     = 36'((sum_x + 67'sd1073741824) >>> 31);
    ry     = 36'((sum_y + 67'sd1073741824) >>> 31);
    vx     = 37'(job_q.pos_x) + 37'(rx);
    vy     = 37'(job_q.pos_y) + 37'(ry);
    if (vx > 37'sd2147483647) begin
      vx_sat = 32'sh7FFF_FFFF;
    end else if (vx < -37'sd2147483648) begin
      vx_sat = 32'sh8000_0000;
    end else begin
      vx_sat = 32'(vx);
    end
    if (vy > 37'sd2147483647) begin
      vy_sat = 32'sh7FFF_FFFF;
    end else if (vy < -37'sd2147483648) begin
      vy_sat = 32'sh8000_0000;
    end else begin
      vy_sat = 32'(vy);
    end
  end

  assign out_load = !out_valid_o || !out_stall_i;

  // Sequencer: take a job, emit its marker if it has one; for a draw, evaluate sine and cosine, emit corners.
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    phase_d   = phase_q;
    corner_d  = corner_q;
    job_d     = job_q;
    x_d       = x_q;
    x2_d      = x2_q;
    t_d       = t_q;
    s_d       = s_q;
    sn_d      = sn_q;
    cs_d      = cs_q;
    prod_d    = prod_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    p3_d      = p3_q;
    p4_d      = p4_q;
    pop_o     = 1'b0;
    emit_mark = 1'b0;
    emit_vert = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          step_d  = 4'd0;
          phase_d = 1'b0;
          state_d = job_i.mark ? B_MARK : B_CALC;
        end
      end
      B_MARK: begin
        if (out_load) begin
          emit_mark = 1'b1;
          state_d   = job_q.draw ? B_CALC : B_IDLE;
        end
      end
      B_CALC: begin
        if (!phase_q) begin
          prod_d  = mul_a * mul_b;
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          step_d  = step_q + 4'd1;
          unique case (step_q)
            4'd0:  x_d  = mq;
            4'd1:  x2_d = mq;
            4'd2:  t_d  = KS_7 - mq;
            4'd3:  t_d  = KS_5 - mq;
            4'd4:  t_d  = KS_3 - mq;
            4'd5:  t_d  = K_ONE - mq;
            4'd6:  s_d  = mq;
            4'd7:  t_d  = KC_8 - mq;
            4'd8:  t_d  = KC_6 - mq;
            4'd9:  t_d  = KC_4 - mq;
            4'd10: t_d  = KC_2 - mq;
            4'd11: begin
              // Map the octant result back to the full turn.
              unique case (oct)
                3'd0: begin sn_d = s_q;    cs_d = c_new;  end
                3'd1: begin sn_d = c_new;  cs_d = s_q;    end
                3'd2: begin sn_d = c_new;  cs_d = -s_q;   end
                3'd3: begin sn_d = s_q;    cs_d = -c_new; end
                3'd4: begin sn_d = -s_q;   cs_d = -c_new; end
                3'd5: begin sn_d = -c_new; cs_d = -s_q;   end
                3'd6: begin sn_d = -c_new; cs_d = s_q;    end
                default: begin sn_d = -s_q; cs_d = c_new; end
              endcase
            end
            4'd12: p1_d = prod_q;
            4'd13: p2_d = prod_q;
            4'd14: p3_d = prod_q;
            default: begin
              p4_d     = prod_q;
              corner_d = 2'd0;
              state_d  = B_VERT;
            end
          endcase
        end
      end
      B_VERT: begin
        if (out_load) begin
          emit_vert = 1'b1;
          corner_d  = corner_q + 2'd1;
          if (corner_q == 2'd3) begin
            state_d = B_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_o <= emit_mark || emit_vert;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    phase_q  <= phase_d;
    corner_q <= corner_d;
    job_q    <= job_d;
    x_q      <= x_d;
    x2_q     <= x2_d;
    t_q      <= t_d;
    s_q      <= s_d;
    sn_q     <= sn_d;
    cs_q     <= cs_d;
    prod_q   <= prod_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    p3_q     <= p3_d;
    p4_q     <= p4_d;
    // Output register, loaded with the next result beat.
    if (emit_mark) begin
      kind_o        <= KIND_MARKER;
      vert_x_o      <= '0;
      vert_y_o      <= '0;
      vert_z_o      <= '0;
      vert_color_o  <= '0;
      tex_u_o       <= 1'b0;
      tex_v_o       <= 1'b0;
      slot_o        <= '0;
      vert_tiling_o <= '0;
      batch_quads_o <= job_q.mark_quads;
      slots_used_o  <= job_q.mark_slots;
      last_o        <= !job_q.draw;
    end else if (emit_vert) begin
      kind_o        <= KIND_VERTEX;
      vert_x_o      <= vx_sat;
      vert_y_o      <= vy_sat;
      vert_z_o      <= job_q.pos_z;
      vert_color_o  <= job_q.color;
      tex_u_o       <= (corner_q == 2'd1) || (corner_q == 2'd2);
      tex_v_o       <= corner_q[1];
      slot_o        <= job_q.slot;
      vert_tiling_o <= job_q.tiling;
      batch_quads_o <= '0;
      slots_used_o  <= '0;
      last_o        <= (corner_q == 2'd3);
    end
  end

  // Sine and cosine never leave the unit range once evaluated.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_VERT) |-> ((cs_q <= K_ONE) && (cs_q >= -K_ONE) &&
                             (sn_q <= K_ONE) && (sn_q >= -K_ONE)))
    else $error("rotation coefficient out of range");

endmodule

// ===== design/batched_quad_vertex_expander.sv =====
// Batched quad vertex expander. Each draw beat becomes four vertex beats
// (corners in the order bottom-left, bottom-right, top-right, top-left), with
// a batch-flush marker beat in front when the quad or texture slot limit is
// reached; end scene gives one marker beat, begin scene and unknown codes give
// none. A front section accepts and classifies a beat, keeps the batch counts
// and searches the texture slot table, with a read and a compare for each
// bound slot inspected. A two-entry job queue feeds the back section, which
// evaluates sine and cosine and the four rotated products on one shared 33x33
// multiplier in 16 steps, each a multiply and then a result update, and then
// emits the vertices, one per cycle while the output is not stalled; this
// multiplier sequence sets the sustained rate.
// The slot table is not cleared at reset; only entries bound in the current
// batch are ever compared.
module batched_quad_vertex_expander import bqve_pkg::*; #(
  parameter int TEX_SLOTS  = 32,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] size_x_i,
  input  logic signed [31:0] size_y_i,
  input  logic [15:0]        angle_i,
  input  logic [31:0]        color_rgba_i,
  input  logic               textured_i,
  input  logic [31:0]        texture_handle_i,
  input  logic [15:0]        tiling_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [31:0] vert_x_o,
  output logic signed [31:0] vert_y_o,
  output logic signed [31:0] vert_z_o,
  output logic [31:0]        vert_color_o,
  output logic               tex_u_o,
  output logic               tex_v_o,
  output logic [4:0]         slot_o,
  output logic [15:0]        vert_tiling_o,
  output logic [15:0]        batch_quads_o,
  output logic [5:0]         slots_used_o,
  output logic               last_o
);

  logic push, full, pop, empty;
  job_t job_in, job_out;

  bqve_front #(.TEX_SLOTS(TEX_SLOTS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .size_x_i        (size_x_i),
    .size_y_i        (size_y_i),
    .angle_i         (angle_i),
    .color_rgba_i    (color_rgba_i),
    .textured_i      (textured_i),
    .texture_handle_i(texture_handle_i),
    .tiling_i        (tiling_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push_o          (push),
    .job_o           (job_in),
    .full_i          (full)
  );

  bqve_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .din_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .dout_o (job_out),
    .empty_o(empty)
  );

  bqve_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .job_i        (job_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .vert_x_o     (vert_x_o),
    .vert_y_o     (vert_y_o),
    .vert_z_o     (vert_z_o),
    .vert_color_o (vert_color_o),
    .tex_u_o      (tex_u_o),
    .tex_v_o      (tex_v_o),
    .slot_o       (slot_o),
    .vert_tiling_o(vert_tiling_o),
    .batch_quads_o(batch_quads_o),
    .slots_used_o (slots_used_o),
    .last_o       (last_o)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  import bqve_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Reserved code: the block ignores it.
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] pos_x, pos_y, pos_z, size_x, size_y;
    logic [15:0] angle;
    logic [31:0] color;
    logic        textured;
    logic [31:0] handle;
    logic [15:0] tiling;
  } request_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] vert_x, vert_y, vert_z, color;
    logic        tex_u, tex_v;
    logic [4:0]  slot;
    logic [15:0] tiling;
    logic [15:0] batch_quads;
    logic [5:0]  slots_used;
    logic        last;
  } vertex_beat_t;

  // Predicts the vertex and marker beats of each request and checks them in order.
  class vertex_scoreboard;
    logic [15:0]  max_quads = 16'd10000;
    logic [5:0]   slot_limit = 6'd32;
    logic [31:0]  bound_handle [32];
    int unsigned  next_slot = 1;
    logic [15:0]  quad_count = 0;
    vertex_beat_t awaited [$];
    int           errors = 0;
    int           quads_seen = 0;
    int           markers_seen = 0;

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == CFG_MAX_QUADS) max_quads = data;
      else slot_limit = data[5:0];
    endfunction

    function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // Octant reduction and Taylor polynomials in Q2.30.
    function void sin_cos(logic [15:0] angle, output longint sn, output longint cs);
      logic [31:0] turn;
      logic [2:0] oct;
      longint unsigned r, x, x2, t, s, c;
      turn = {angle, 16'd0};
      oct = turn[31:29];
      r = 64'(turn[28:0]);
      if (oct[0]) r = (64'd1 << 29) - r;
      x = (r * 64'd1686629713 + (64'd1 << 29)) >> 30;
      x2 = q30_mul(x, x);
      t = 2959;
      t = 213044 - q30_mul(x2, t);
      t = 8947849 - q30_mul(x2, t);
      t = 178956971 - q30_mul(x2, t);
      t = 64'd1073741824 - q30_mul(x2, t);
      s = q30_mul(x, t);
      t = 296;
      t = 26631 - q30_mul(x2, t);
      t = 1491308 - q30_mul(x2, t);
      t = 44739243 - q30_mul(x2, t);
      t = 536870912 - q30_mul(x2, t);
      c = 64'd1073741824 - q30_mul(x2, t);
      case (oct)
        3'd0: begin sn = s;  cs = c;  end
        3'd1: begin sn = c;  cs = s;  end
        3'd2: begin sn = c;  cs = -s; end
        3'd3: begin sn = s;  cs = -c; end
        3'd4: begin sn = -s; cs = -c; end
        3'd5: begin sn = -c; cs = -s; end
        3'd6: begin sn = -c; cs = s;  end
        default: begin sn = -s; cs = c; end
      endcase
    endfunction

    // Rounds half up from units of 2^-47 to Q16.16.
    function longint to_q16(longint v);
      longint unsigned u;
      u = longint'(v) + (64'd1 << 62) + (64'd1 << 30);
      return longint'(u >> 31) - 64'sh80000000;
    endfunction

    function logic [31:0] saturate(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function void push_marker();
      vertex_beat_t m;
      m = '0;
      m.kind = KIND_MARKER;
      m.batch_quads = quad_count;
      m.slots_used = next_slot[5:0];
      awaited.push_back(m);
    endfunction

    function void note_request(request_t rq);
      int unsigned lim, slot;
      longint sn, cs, ax, ay, szx, szy, rx, ry;
      vertex_beat_t v;
      logic [15:0] tiling;
      if (rq.op == OP_BEGIN) begin
        quad_count = 0;
        next_slot = 1;
        return;
      end
      if (rq.op == OP_NONE) return;
      if (rq.op == OP_END) begin
        push_marker();
      end else begin
        lim = slot_limit < 2 ? 2 : (slot_limit > 32 ? 32 : slot_limit);
        if (quad_count >= (max_quads == 0 ? 16'd1 : max_quads)) begin
          push_marker();
          quad_count = 0;
          next_slot = 1;
        end
        slot = 0;
        tiling = 16'd256;
        if (rq.textured) begin
          tiling = rq.tiling;
          for (int i = 1; i < next_slot; i++) begin
            if (bound_handle[i] == rq.handle) begin
              slot = i;
              break;
            end
          end
          if (slot == 0) begin
            if (next_slot >= lim) begin
              push_marker();
              quad_count = 0;
              next_slot = 1;
            end
            bound_handle[next_slot % 32] = rq.handle;
            slot = next_slot;
            next_slot++;
          end
        end
        sin_cos(rq.angle, sn, cs);
        szx = longint'(signed'(rq.size_x));
        szy = longint'(signed'(rq.size_y));
        // Corners bottom-left, bottom-right, top-right, top-left.
        for (int k = 0; k < 4; k++) begin
          ax = (k == 1 || k == 2) ? szx : -szx;
          ay = (k >= 2) ? szy : -szy;
          rx = to_q16(ax * cs - ay * sn);
          ry = to_q16(ax * sn + ay * cs);
          v = '0;
          v.kind = KIND_VERTEX;
          v.vert_x = saturate(longint'(signed'(rq.pos_x)) + rx);
          v.vert_y = saturate(longint'(signed'(rq.pos_y)) + ry);
          v.vert_z = rq.pos_z;
          v.color = rq.color;
          v.tex_u = (k == 1 || k == 2);
          v.tex_v = (k >= 2);
          v.slot = slot[4:0];
          v.tiling = tiling;
          awaited.push_back(v);
        end
        quad_count++;
      end
      awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    function void check_beat(vertex_beat_t got);
      vertex_beat_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.kind == KIND_MARKER) markers_seen++;
      else if (got.last) quads_seen++;
      if (got !== want) begin
        $display("%0t: beat differs\n  expected %p\n  actual   %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] op_i = OP_BEGIN;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0, size_x_i = '0, size_y_i = '0;
  logic [15:0] angle_i = '0;
  logic [31:0] color_rgba_i = '0;
  logic textured_i = 1'b0;
  logic [31:0] texture_handle_i = '0;
  logic [15:0] tiling_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o, tex_u_o, tex_v_o, last_o;
  logic signed [31:0] vert_x_o, vert_y_o, vert_z_o;
  logic [31:0] vert_color_o;
  logic [4:0] slot_o;
  logic [15:0] vert_tiling_o, batch_quads_o;
  logic [5:0] slots_used_o;

  batched_quad_vertex_expander dut (.*);

  vertex_scoreboard sb = new();
  int sender_idle_pct = 14;
  int receiver_stall_pct = 86;
  int cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Output side: check accepted beats and stall at random.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat({kind_o, vert_x_o, vert_y_o, vert_z_o, vert_color_o, tex_u_o, tex_v_o,
                     slot_o, vert_tiling_o, batch_quads_o, slots_used_o, last_o});
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Run guard.
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("batched_quad_vertex_expander: mismatch");
      $finish;
    end
  end

  task automatic send_request(request_t rq);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= rq.op;
    pos_x_i <= rq.pos_x;
    pos_y_i <= rq.pos_y;
    pos_z_i <= rq.pos_z;
    size_x_i <= rq.size_x;
    size_y_i <= rq.size_y;
    angle_i <= rq.angle;
    color_rgba_i <= rq.color;
    textured_i <= rq.textured;
    texture_handle_i <= rq.handle;
    tiling_i <= rq.tiling;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(rq);
  endtask

  // Waits for all results, then lets a textured search in a full batch finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 8 << 16);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int r;
    r = $urandom_range(99);
    rq.op = r < 78 ? OP_DRAW : (r < 86 ? OP_END : (r < 94 ? OP_BEGIN : OP_NONE));
    rq.pos_x = pick_coord();
    rq.pos_y = pick_coord();
    rq.pos_z = $urandom;
    rq.size_x = pick_coord();
    rq.size_y = pick_coord();
    rq.angle = 16'($urandom);
    rq.color = $urandom;
    rq.textured = $urandom_range(99) < 60;
    rq.handle = $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 9);
    rq.tiling = 16'($urandom);
    return rq;
  endfunction

  function automatic request_t make_draw(logic [31:0] px, logic [31:0] sz,
                                         logic [15:0] ang, logic tex, logic [31:0] h);
    request_t rq;
    rq = '{op: OP_DRAW, pos_x: px, pos_y: ~px, pos_z: ~px, size_x: sz, size_y: ~sz,
           angle: ang, color: ~h, textured: tex, handle: h, tiling: ang};
    return rq;
  endfunction

  initial begin
    request_t rq;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats: field extremes, every op, slot hits and misses.
    write_reg(CFG_MAX_QUADS, 16'hffff);
    write_reg(CFG_SLOT_LIMIT, 6'd63);
    send_request(make_draw(32'h0, 32'h0001_0000, 16'h0000, 1'b0, 32'h0));
    send_request(make_draw(32'h7fffffff, 32'h7fffffff, 16'hffff, 1'b1, 32'hffffffff));
    send_request(make_draw(32'h80000000, 32'h80000000, 16'h2000, 1'b1, 32'h0));
    send_request(make_draw(32'h0001_8000, 32'hffff_0000, 16'h4000, 1'b1, 32'hffffffff));
    send_request(make_draw(32'hfff0_0000, 32'h0003_0001, 16'h6000, 1'b1, 32'h1234));
    send_request(make_draw(32'h7fff_ffff, 32'h8000_0001, 16'h8000, 1'b0, 32'h1));
    send_request(make_draw(32'h5555_5555, 32'haaaa_aaaa, 16'hc000, 1'b1, 32'h1234));
    rq = make_draw(0, 0, 0, 0, 0);
    rq.op = OP_NONE;
    send_request(rq);
    rq.op = OP_END;
    send_request(rq);
    rq.op = OP_BEGIN;
    send_request(rq);
    rq.op = OP_END;
    send_request(rq);
    drain();

    // Each setting runs a random stretch; the last ones use no idling at all.
    for (int ph = 0; ph < 5; ph++) begin
      sender_idle_pct = ph == 0 ? 14 : (ph == 1 ? 86 : 0);
      receiver_stall_pct = ph == 0 ? 86 : (ph == 1 ? 14 : 0);
      case (ph)
        0: begin write_reg(CFG_MAX_QUADS, 16'd10000); write_reg(CFG_SLOT_LIMIT, 6'd32); end
        1: begin write_reg(CFG_MAX_QUADS, 16'd3); write_reg(CFG_SLOT_LIMIT, 6'd2); end
        2: begin write_reg(CFG_MAX_QUADS, 16'd0); write_reg(CFG_SLOT_LIMIT, 6'd1); end
        3: begin write_reg(CFG_MAX_QUADS, 16'd1); write_reg(CFG_SLOT_LIMIT, 6'd4); end
        default: begin write_reg(CFG_MAX_QUADS, 16'd7); write_reg(CFG_SLOT_LIMIT, 6'd0); end
      endcase
      for (int n = 0; n < 52; n++) begin
        send_request(random_request());
        // Hold the sender back once per stretch until the output is empty.
        if (n == 20) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (sb.awaited.size() != 0);
        end
      end
      drain();
    end

    $display("Covered %0d quads and %0d flush markers over five limit settings.",
             sb.quads_seen, sb.markers_seen);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("batched_quad_vertex_expander: match");
    end else begin
      $display("batched_quad_vertex_expander: mismatch");
    end
    $finish;
  end
endmodule
